[design/mcpt_pkg.sv]
// ----------------------------------------------------------------------------
// mcpt_pkg
// Shared types and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
package mcpt_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int MAX_RESULTS    = 8;
   localparam int FIRE_CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int TIDX_W         = 4;
   localparam int TVAL_W         = 32;
   localparam int AMT_W          = 8;
   localparam int CNT_W          = 32;
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 72;

   typedef enum logic [2:0] {
      ACT_ADVANCE   = 3'd0,
      ACT_SET       = 3'd1,
      ACT_CLR_COUNT = 3'd2,
      ACT_QUERY     = 3'd3,
      ACT_CLR_ELAP  = 3'd4,
      ACT_CLR_STATE = 3'd5,
      ACT_RSVD6     = 3'd6,
      ACT_RSVD7     = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      BANK_NOP,
      BANK_STEP,
      BANK_SET,
      BANK_CLR
   } bank_op_type;

   typedef struct packed {
      bank_op_type         op;
      logic [TIDX_W-1:0]   idx;
      logic                arm;
      logic [TVAL_W-1:0]   tval;
   } bank_cmd_type;

   typedef struct packed {
      logic fire;
      logic ge;
   } bank_status_type;

endpackage

[design/multi_channel_periodic_timer.sv]
// a non-advance item goes from idle to ST_FIN, which loads its result registers
// an advance walks one channel per cycle while the output is free, then ST_FIN
//   loads the last result; a new item is taken only in idle, once the last one is
//   through; the channel bank has a single shared add/compare unit
// a stalled result beat holds the walk until it is taken
// reset clears all channels and both elapsed counters
// ----------------------------------------------------------------------------
// multi_channel_periodic_timer
// Bank of periodic timer channels advanced by stream items, reporting fires.
// ----------------------------------------------------------------------------
module multi_channel_periodic_timer #(
   parameter int NUM_TIMERS = mcpt_pkg::NUM_TIMERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // timer_index, timeout_value, arm, elapsed_amount, zero pad
   input  logic [mcpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [2:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fire_valid, fired_index, expired, elapsed_total, state_elapsed, zero pad
   output logic [mcpt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int WALK_W = $clog2(NUM_TIMERS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FIN
   } state_type;

   state_type                        state_ff;
   mcpt_pkg::action_type             action_ff;
   logic [mcpt_pkg::TIDX_W-1:0]      idx_ff;
   logic                             idx_ok_ff;
   logic [mcpt_pkg::TVAL_W-1:0]      tval_ff;
   logic [mcpt_pkg::AMT_W-1:0]       amt_ff;
   logic [WALK_W-1:0]                walk_ff;
   logic                             pend_valid_ff;
   logic [IDX_W-1:0]                 pend_idx_ff;
   logic [mcpt_pkg::FIRE_CNT_W-1:0]  nfire_ff;
   logic [mcpt_pkg::CNT_W-1:0]       elapsed_ff;
   logic [mcpt_pkg::CNT_W-1:0]       state_cnt_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_fire_ff;
   logic [mcpt_pkg::TIDX_W-1:0]      rsp_idx_ff;
   logic                             rsp_exp_ff;
   logic [mcpt_pkg::CNT_W-1:0]       rsp_elap_ff;
   logic [mcpt_pkg::CNT_W-1:0]       rsp_state_ff;
   logic                             rsp_last_ff;

   mcpt_pkg::action_type             req_action;
   logic [mcpt_pkg::TIDX_W-1:0]      req_idx;
   logic [mcpt_pkg::TVAL_W-1:0]      req_tval;
   logic                             req_arm;
   logic [mcpt_pkg::AMT_W-1:0]       req_amt;
   logic                             req_idx_ok;
   logic                             accept;
   logic                             out_free;
   logic                             last_chan;
   logic                             report;
   logic                             rsp_load;
   logic [IDX_W-1:0]                 rd_idx;
   mcpt_pkg::bank_cmd_type           cmd;
   mcpt_pkg::bank_status_type        status;

   assign req_action = mcpt_pkg::action_type'(req_tuser);
   assign req_idx    = req_tdata[3:0];
   assign req_tval   = req_tdata[35:4];
   assign req_arm    = req_tdata[36];
   assign req_amt    = req_tdata[44:37];
   assign req_idx_ok = {1'b0, req_idx} < (mcpt_pkg::TIDX_W + 1)'(NUM_TIMERS);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_chan  = walk_ff == WALK_W'(NUM_TIMERS - 1);
   assign report     = status.fire && (nfire_ff < mcpt_pkg::FIRE_CNT_W'(mcpt_pkg::MAX_RESULTS));
   assign rd_idx     = (state_ff == ST_WALK) ? walk_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign rsp_load   = out_free && (((state_ff == ST_WALK) && report && pend_valid_ff) ||
                                    (state_ff == ST_FIN));

   always_comb begin
      cmd.op   = mcpt_pkg::BANK_NOP;
      cmd.idx  = req_idx;
      cmd.arm  = req_arm;
      cmd.tval = req_tval;
      if (accept && req_idx_ok && (req_action == mcpt_pkg::ACT_SET)) begin
         cmd.op = mcpt_pkg::BANK_SET;
      end else if (accept && req_idx_ok && (req_action == mcpt_pkg::ACT_CLR_COUNT)) begin
         cmd.op = mcpt_pkg::BANK_CLR;
      end else if ((state_ff == ST_WALK) && out_free) begin
         cmd.op = mcpt_pkg::BANK_STEP;
      end
   end

   mcpt_chan_bank #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_bank (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .amt    (amt_ff),
      .thresh (tval_ff),
      .cmd    (cmd),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         nfire_ff      <= '0;
         walk_ff       <= '0;
         elapsed_ff    <= '0;
         state_cnt_ff  <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  action_ff     <= req_action;
                  idx_ff        <= req_idx;
                  idx_ok_ff     <= req_idx_ok;
                  tval_ff       <= req_tval;
                  amt_ff        <= req_amt;
                  walk_ff       <= '0;
                  nfire_ff      <= '0;
                  pend_valid_ff <= 1'b0;
                  unique case (req_action)
                     mcpt_pkg::ACT_ADVANCE: begin
                        elapsed_ff   <= elapsed_ff + mcpt_pkg::CNT_W'(req_amt);
                        state_cnt_ff <= state_cnt_ff + mcpt_pkg::CNT_W'(req_amt);
                        state_ff     <= ST_WALK;
                     end
                     mcpt_pkg::ACT_CLR_ELAP: begin
                        elapsed_ff <= '0;
                        state_ff   <= ST_FIN;
                     end
                     mcpt_pkg::ACT_CLR_STATE: begin
                        state_cnt_ff <= '0;
                        state_ff     <= ST_FIN;
                     end
                     default: begin
                        state_ff <= ST_FIN;
                     end
                  endcase
               end
            end
            ST_WALK: begin
               if (out_free) begin
                  // hold one fire back so the final one can carry tlast
                  if (report) begin
                     nfire_ff      <= nfire_ff + mcpt_pkg::FIRE_CNT_W'(1);
                     pend_valid_ff <= 1'b1;
                     pend_idx_ff   <= walk_ff[IDX_W-1:0];
                     if (pend_valid_ff) begin
                        rsp_fire_ff  <= 1'b1;
                        rsp_idx_ff   <= mcpt_pkg::TIDX_W'(pend_idx_ff);
                        rsp_exp_ff   <= 1'b0;
                        rsp_elap_ff  <= elapsed_ff;
                        rsp_state_ff <= state_cnt_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                  end
                  walk_ff <= walk_ff + WALK_W'(1);
                  if (last_chan) begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_fire_ff   <= pend_valid_ff;
                  rsp_idx_ff    <= pend_valid_ff ? mcpt_pkg::TIDX_W'(pend_idx_ff) : '0;
                  rsp_exp_ff    <= (action_ff == mcpt_pkg::ACT_QUERY) && idx_ok_ff && status.ge;
                  rsp_elap_ff   <= elapsed_ff;
                  rsp_state_ff  <= state_cnt_ff;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_state_ff, rsp_elap_ff, rsp_exp_ff, rsp_idx_ff, rsp_fire_ff};

`ifndef SYNTHESIS
   a_fire_idx_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fire_ff) |-> ({1'b0, rsp_idx_ff} < (mcpt_pkg::TIDX_W + 1)'(NUM_TIMERS)))
      else $error("fire beat reports a channel outside the bank");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_fire_ff) |-> rsp_last_ff)
      else $error("status beat without tlast");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> ((state_ff == ST_WALK) || (state_ff == ST_FIN)))
      else $error("held fire outside the channel walk");

   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      nfire_ff <= mcpt_pkg::FIRE_CNT_W'(mcpt_pkg::MAX_RESULTS))
      else $error("too many fires reported for one advance");

   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && out_free && last_chan) |=> (state_ff == ST_FIN))
      else $error("walk did not finish after the last channel");
`endif

endmodule

[design/mcpt_chan_bank.sv]
// ----------------------------------------------------------------------------
// mcpt_chan_bank
// Channel count, timeout and armed storage with one shared saturating adder,
// fire comparator and threshold comparator, used once per cycle on the channel at rd_idx.
// ----------------------------------------------------------------------------
module mcpt_chan_bank #(
   parameter int NUM_TIMERS = mcpt_pkg::NUM_TIMERS_DEF,
   parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [IDX_W-1:0]               rd_idx,
   input  logic [mcpt_pkg::AMT_W-1:0]     amt,
   input  logic [mcpt_pkg::TVAL_W-1:0]    thresh,
   input  mcpt_pkg::bank_cmd_type         cmd,
   output mcpt_pkg::bank_status_type      status
);

   logic [mcpt_pkg::CNT_W-1:0]  count_ff   [NUM_TIMERS];
   logic [mcpt_pkg::TVAL_W-1:0] timeout_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]       armed_ff;

   logic [mcpt_pkg::CNT_W-1:0]  cur;
   logic [mcpt_pkg::TVAL_W-1:0] cur_to;
   logic [mcpt_pkg::CNT_W:0]    sum;
   logic [mcpt_pkg::CNT_W-1:0]  sat;
   logic [IDX_W-1:0]            wr_idx;

   assign cur    = count_ff[rd_idx];
   assign cur_to = timeout_ff[rd_idx];
   assign sum    = {1'b0, cur} + {{(mcpt_pkg::CNT_W + 1 - mcpt_pkg::AMT_W){1'b0}}, amt};
   assign sat    = sum[mcpt_pkg::CNT_W] ? {mcpt_pkg::CNT_W{1'b1}} : sum[mcpt_pkg::CNT_W-1:0];
   assign wr_idx = cmd.idx[IDX_W-1:0];

   assign status.fire = armed_ff[rd_idx] && (cur_to != '0) && (sat >= cur_to);
   assign status.ge   = cur >= thresh;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            count_ff[i]   <= '0;
            timeout_ff[i] <= '0;
         end
         armed_ff <= '0;
      end else begin
         unique case (cmd.op)
            mcpt_pkg::BANK_STEP: begin
               count_ff[rd_idx] <= status.fire ? '0 : sat;
            end
            mcpt_pkg::BANK_SET: begin
               count_ff[wr_idx]   <= '0;
               armed_ff[wr_idx]   <= cmd.arm;
               timeout_ff[wr_idx] <= cmd.arm ? cmd.tval : '0;
            end
            mcpt_pkg::BANK_CLR: begin
               count_ff[wr_idx] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule
